// ===== rtl/core/mp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp_pkg
// Shared widths, register indexes and defaults of the matrix power block.
// ----------------------------------------------------------------------------
package mp_pkg;

    localparam int DATA_W      = 32;  // element and result width
    localparam int SIZE_W      = 4;   // size_in_use register width
    localparam int POWER_W     = 8;   // power register width
    localparam int CFG_IDX_W   = 1;   // configuration register index width
    localparam int CFG_DATA_W  = 8;   // widest configuration register
    localparam int MAX_DIM_DEF = 8;   // default largest matrix dimension

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER       = 1'd1;

    // register values after reset
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 4'd1;
    localparam logic [POWER_W-1:0] POWER_RESET = 8'd1;

endpackage
`default_nettype wire

// ===== rtl/core/matrix_power_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_power_top
// Loads an n-by-n signed matrix row-major and emits it raised to a power,
// using one shared multiply-accumulate unit under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | payload                        | handshake
//  s_       | in        | tdata: element_value           | tvalid/tready
//  m_       | out       | tdata: result_value, tlast     | tvalid/tready
//  cfg_     | in        | index 0 size_in_use, 1 power   | cfg_we, no wait
//
//  Non-final elements are only stored, taken back to back. The final element
//  starts computation: power 0 or 1 goes straight to output; power p >= 2
//  runs (p-1) rounds of n*n dot products on the single MAC, each of n terms
//  fed through the read and multiply registers. Each result passes ST_OUT_RD,
//  ST_OUT_WAIT and ST_OUT_HOLD, holding for m_tready. s_tready is low from
//  the final element until the last result is taken. Reset is synchronous,
//  active low, and sets size_in_use and power to 1 and the load count to 0.
// ----------------------------------------------------------------------------
module matrix_power_top #(
    parameter int MAX_DIM = mp_pkg::MAX_DIM_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic signed [mp_pkg::DATA_W-1:0] s_tdata,  // [31:0] element_value
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic signed [mp_pkg::DATA_W-1:0]   m_tdata,     // [31:0] result_value
    output logic                               m_tlast,     // last_of_run
    // configuration writes
    input  wire logic                          cfg_we,
    input  wire logic [mp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DW    = mp_pkg::DATA_W;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int NW    = $clog2(MAX_DIM + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } state_t;

    typedef enum logic [1:0] {
        SRC_IDENT,
        SRC_BASE,
        SRC_BUF0,
        SRC_BUF1
    } src_t;

    // configuration
    logic [mp_pkg::SIZE_W-1:0]  size_reg;
    logic [mp_pkg::POWER_W-1:0] power_reg;

    // sequencer state
    state_t                     state_reg;
    src_t                       src_reg;
    logic                       dst_reg;
    logic [mp_pkg::POWER_W-1:0] rounds_reg;
    logic [AW-1:0]              load_cnt_reg;
    logic [NW-1:0]              i_reg;
    logic [NW-1:0]              j_reg;
    logic [NW-1:0]              k_reg;
    logic [AW-1:0]              e_reg;
    logic [AW-1:0]              row_base_reg;
    logic [AW-1:0]              a_addr_reg;
    logic [AW-1:0]              b_addr_reg;

    // MAC pipeline
    logic          s1_vld_reg, s1_first_reg, s1_last_reg;
    logic          s2_vld_reg, s2_first_reg, s2_last_reg;
    logic [DW-1:0] mul_reg;
    logic [DW-1:0] acc_reg;

    // output register
    logic          m_tvalid_reg;
    logic          m_tlast_reg;
    logic [DW-1:0] m_tdata_reg;

    // memories
    logic [DW-1:0] base_mem [DEPTH];
    logic [DW-1:0] buf0_mem [DEPTH];
    logic [DW-1:0] buf1_mem [DEPTH];
    logic [DW-1:0] base_a_q, base_b_q, buf0_q, buf1_q;

    // combinational
    logic [NW-1:0]   n_act;
    logic [NW-1:0]   n_m1;
    logic [TW-1:0]   total;
    logic [TW-1:0]   load_cnt_next;
    logic            s_accept;
    logic            rd_en;
    logic [AW-1:0]   rd_a_addr;
    logic [DW-1:0]   a_data;
    logic [2*DW-1:0] mul_full;
    logic [DW-1:0]   acc_sum;
    logic            acc_we;
    logic            out_last;

    always_comb begin
        if (size_reg == '0) begin
            n_act = NW'(1);
        end else if (size_reg > mp_pkg::SIZE_W'(MAX_DIM)) begin
            n_act = NW'(MAX_DIM);
        end else begin
            n_act = NW'(size_reg);
        end
    end

    assign n_m1          = n_act - NW'(1);
    assign total         = TW'(n_act) * TW'(n_act);
    assign load_cnt_next = TW'(load_cnt_reg) + TW'(1);
    assign s_accept      = s_tvalid && s_tready;
    assign out_last      = (TW'(e_reg) + TW'(1)) == total;

    assign rd_en     = (state_reg == ST_ISSUE) || (state_reg == ST_OUT_RD);
    assign rd_a_addr = (state_reg == ST_OUT_RD) ? e_reg : a_addr_reg;

    always_comb begin
        unique case (src_reg)
            SRC_BASE:  a_data = base_a_q;
            SRC_BUF0:  a_data = buf0_q;
            SRC_BUF1:  a_data = buf1_q;
            default:   a_data = base_a_q;
        endcase
    end

    assign mul_full = a_data * base_b_q;
    assign acc_sum  = (s2_first_reg ? '0 : acc_reg) + mul_reg;
    assign acc_we   = s2_vld_reg && s2_last_reg;

    // ---------------- memories ----------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            base_mem[load_cnt_reg] <= s_tdata;
        end
        if (rd_en) begin
            base_a_q <= base_mem[rd_a_addr];
            base_b_q <= base_mem[b_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_we && !dst_reg) begin
            buf0_mem[e_reg] <= acc_sum;
        end
        if (rd_en) begin
            buf0_q <= buf0_mem[rd_a_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_we && dst_reg) begin
            buf1_mem[e_reg] <= acc_sum;
        end
        if (rd_en) begin
            buf1_q <= buf1_mem[rd_a_addr];
        end
    end

    // ---------------- MAC datapath ----------------
    always_ff @(posedge aclk) begin
        mul_reg <= mul_full[DW-1:0];
        if (s2_vld_reg) begin
            acc_reg <= acc_sum;
        end
        s1_first_reg <= (k_reg == '0);
        s1_last_reg  <= (k_reg == n_m1);
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= mp_pkg::SIZE_RESET;
            power_reg <= mp_pkg::POWER_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mp_pkg::REG_SIZE_IN_USE: size_reg  <= cfg_wdata[mp_pkg::SIZE_W-1:0];
                mp_pkg::REG_POWER:       power_reg <= cfg_wdata[mp_pkg::POWER_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            src_reg      <= SRC_BASE;
            dst_reg      <= 1'b0;
            rounds_reg   <= '0;
            load_cnt_reg <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            e_reg        <= '0;
            row_base_reg <= '0;
            a_addr_reg   <= '0;
            b_addr_reg   <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            s1_vld_reg <= (state_reg == ST_ISSUE);
            s2_vld_reg <= s1_vld_reg;

            unique case (state_reg)
                ST_LOAD: begin
                    if (s_accept) begin
                        if (load_cnt_next < total) begin
                            load_cnt_reg <= AW'(load_cnt_next);
                        end else begin
                            load_cnt_reg <= '0;
                            i_reg        <= '0;
                            j_reg        <= '0;
                            k_reg        <= '0;
                            e_reg        <= '0;
                            row_base_reg <= '0;
                            a_addr_reg   <= '0;
                            b_addr_reg   <= '0;
                            dst_reg      <= 1'b0;
                            rounds_reg   <= power_reg - mp_pkg::POWER_W'(1);
                            if (power_reg == '0) begin
                                src_reg   <= SRC_IDENT;
                                state_reg <= ST_OUT_RD;
                            end else if (power_reg == mp_pkg::POWER_W'(1)) begin
                                src_reg   <= SRC_BASE;
                                state_reg <= ST_OUT_RD;
                            end else begin
                                src_reg   <= SRC_BASE;
                                state_reg <= ST_ISSUE;
                            end
                        end
                    end
                end

                ST_ISSUE: begin
                    // stream one term of the dot product per cycle
                    a_addr_reg <= a_addr_reg + AW'(1);
                    b_addr_reg <= b_addr_reg + AW'(n_act);
                    if (k_reg == n_m1) begin
                        k_reg     <= '0;
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg + NW'(1);
                    end
                end

                ST_DRAIN: begin
                    if (acc_we) begin
                        if (j_reg == n_m1) begin
                            j_reg      <= '0;
                            b_addr_reg <= '0;
                            if (i_reg == n_m1) begin
                                // round done: product becomes the running power
                                i_reg        <= '0;
                                e_reg        <= '0;
                                row_base_reg <= '0;
                                a_addr_reg   <= '0;
                                rounds_reg   <= rounds_reg - mp_pkg::POWER_W'(1);
                                src_reg      <= dst_reg ? SRC_BUF1 : SRC_BUF0;
                                dst_reg      <= !dst_reg;
                                if (rounds_reg == mp_pkg::POWER_W'(1)) begin
                                    state_reg <= ST_OUT_RD;
                                end else begin
                                    state_reg <= ST_ISSUE;
                                end
                            end else begin
                                state_reg    <= ST_ISSUE;
                                e_reg        <= e_reg + AW'(1);
                                i_reg        <= i_reg + NW'(1);
                                row_base_reg <= row_base_reg + AW'(n_act);
                                a_addr_reg   <= row_base_reg + AW'(n_act);
                            end
                        end else begin
                            state_reg  <= ST_ISSUE;
                            e_reg      <= e_reg + AW'(1);
                            j_reg      <= j_reg + NW'(1);
                            a_addr_reg <= row_base_reg;
                            b_addr_reg <= AW'(j_reg + NW'(1));
                        end
                    end
                end

                ST_OUT_RD: begin
                    state_reg <= ST_OUT_WAIT;
                end

                ST_OUT_WAIT: begin
                    if (src_reg == SRC_IDENT) begin
                        m_tdata_reg <= (i_reg == j_reg) ? DW'(1) : '0;
                    end else begin
                        m_tdata_reg <= a_data;
                    end
                    m_tlast_reg  <= out_last;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= ST_OUT_HOLD;
                end

                ST_OUT_HOLD: begin
                    // hold the result until the request is taken
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (m_tlast_reg) begin
                            state_reg <= ST_LOAD;
                        end else begin
                            e_reg     <= e_reg + AW'(1);
                            state_reg <= ST_OUT_RD;
                            if (j_reg == n_m1) begin
                                j_reg <= '0;
                                i_reg <= i_reg + NW'(1);
                            end else begin
                                j_reg <= j_reg + NW'(1);
                            end
                        end
                    end
                end

                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- assertions ----------------
    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_write_in_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_we |-> (state_reg == ST_DRAIN))
        else $error("product written outside of a compute round");

    a_rounds_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE) |-> (rounds_reg != '0))
        else $error("multiply round started with no rounds left");

    a_mac_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE) |-> (src_reg != SRC_IDENT))
        else $error("identity selected as multiply operand");

endmodule
`default_nettype wire
